FILE: hdl/tshm_pkg.sv
// Package for the TDMA host slot manager.
// Holds the event, packet and action codes, register indexes and shared structs.
// No dependencies; every other file imports it.
package tshm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    typedef enum logic [1:0] {
        REQ_PACKET = 2'd0,
        REQ_SYNC   = 2'd1,
        REQ_START  = 2'd2,
        REQ_TICK   = 2'd3
    } req_t;

    localparam logic [1:0] PKT_DATA = 2'd0;
    localparam logic [1:0] PKT_JOIN = 2'd1;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_STORED  = 3'd1,
        ACT_REMOVED = 3'd2,
        ACT_JOIN    = 3'd3,
        ACT_SYNC    = 3'd4,
        ACT_LISTEN  = 3'd5,
        ACT_FULL    = 3'd6
    } action_t;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_UNIT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_WINDOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_POWER      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_OFF      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SLOT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ADVERT_SLOT   = 3'd5;

    typedef struct packed {
        logic [15:0] slot_unit;
        logic [18:0] listen_window;
        logic [7:0]  tx_power;
        logic [7:0]  turn_off;
        logic [3:0]  first_slot;
        logic [7:0]  advert_slot;
    } cfg_t;

    typedef struct packed {
        req_t       req_type;
        logic       crc_ok;
        logic [1:0] packet_kind;
        logic [3:0] slot_id;
        logic       disconnect;
    } item_t;

    typedef struct packed {
        action_t     action;
        logic [3:0]  slot;
        logic [20:0] slot_offset;
        logic [18:0] window;
        logic [3:0]  approval_bits;
        logic [7:0]  power_code;
        logic [7:0]  shutdown_code;
        logic [3:0]  connected_count;
        logic [7:0]  listen_channel;
    } res_t;

endpackage

FILE: hdl/tshm_ifs.sv
// Channel interfaces of the TDMA host slot manager: event input, result output
// and configuration writes. Depends on tshm_pkg.
interface tshm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic       crc_ok;
    logic [1:0] packet_kind;
    logic [3:0] slot_id;
    logic       disconnect;

    modport source (output valid, req_type, crc_ok, packet_kind, slot_id, disconnect,
                    input ready);
    modport sink (input valid, req_type, crc_ok, packet_kind, slot_id, disconnect,
                  output ready);
endinterface

interface tshm_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [3:0]  slot;
    logic [20:0] slot_offset;
    logic [18:0] window;
    logic [3:0]  approval_bits;
    logic [7:0]  power_code;
    logic [7:0]  shutdown_code;
    logic [3:0]  connected_count;
    logic [7:0]  listen_channel;

    modport source (output valid, action, slot, slot_offset, window, approval_bits,
                    power_code, shutdown_code, connected_count, listen_channel,
                    input ready);
    modport sink (input valid, action, slot, slot_offset, window, approval_bits,
                  power_code, shutdown_code, connected_count, listen_channel,
                  output ready);
endinterface

interface tshm_cfg_if import tshm_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/tshm_cfg_regs.sv
// Configuration register file of the TDMA host slot manager.
// Depends on tshm_pkg and tshm_cfg_if.
module tshm_cfg_regs import tshm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    tshm_cfg_if.sink       cfg,
    output cfg_t           regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_SLOT_UNIT:     regs_next.slot_unit     = cfg.data[15:0];
                CFG_LISTEN_WINDOW: regs_next.listen_window = cfg.data[18:0];
                CFG_TX_POWER:      regs_next.tx_power      = cfg.data[7:0];
                CFG_TURN_OFF:      regs_next.turn_off      = cfg.data[7:0];
                CFG_FIRST_SLOT:    regs_next.first_slot    = cfg.data[3:0];
                CFG_ADVERT_SLOT:   regs_next.advert_slot   = cfg.data[7:0];
                default:           regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.slot_unit     <= 16'd4096;
            regs_reg.listen_window <= 19'd32733;
            regs_reg.tx_power      <= 8'd1;
            regs_reg.turn_off      <= 8'd0;
            regs_reg.first_slot    <= 4'd0;
            regs_reg.advert_slot   <= 8'd4;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

FILE: hdl/tshm_engine.sv
// Slot bookkeeping and event decode of the TDMA host slot manager.
// Holds the connected map, sensor count, approval map and slot sequencer.
// Depends on tshm_pkg.
module tshm_engine import tshm_pkg::*;
#(
    parameter int NUM_SLOTS = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  item_t item,
    input  cfg_t  regs,
    output res_t  res
);

    logic [NUM_SLOTS-1:0] connected_map_reg, connected_map_next;
    logic [NUM_SLOTS-1:0] approval_map_reg, approval_map_next;
    logic [3:0]           sensor_count_reg, sensor_count_next;
    logic [7:0]           current_slot_reg, current_slot_next;

    logic [15:0]          conn16;
    logic [15:0]          appr16;
    logic [15:0]          sid_hot;
    logic                 sid_ok;
    logic                 free_found;
    logic [3:0]           free_idx;
    logic [15:0]          free_hot;
    logic [20:0]          join_offset;
    logic [7:0]           tick_slot;
    logic                 tick_used;

    assign conn16  = 16'(connected_map_reg);
    assign appr16  = 16'(approval_map_reg);
    assign sid_hot = 16'd1 << item.slot_id;
    assign sid_ok  = {1'b0, item.slot_id} < 5'(NUM_SLOTS);

    // Lowest free slot.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = 4'd0;
        for (int s = NUM_SLOTS - 1; s >= 0; s--)
        begin
            if (!connected_map_reg[s])
            begin
                free_found = 1'b1;
                free_idx   = 4'(s);
            end
        end
    end

    assign free_hot    = 16'd1 << free_idx;
    assign join_offset = 21'(regs.slot_unit) * 21'({free_idx, 1'b1});

    // Slots past the table read as empty through the zero-padded map.
    assign tick_slot = (item.req_type == REQ_START) ? 8'(regs.first_slot) : current_slot_reg;
    assign tick_used = (tick_slot[7:4] == 4'd0) && conn16[tick_slot[3:0]];

    always_comb
    begin
        connected_map_next = connected_map_reg;
        approval_map_next  = approval_map_reg;
        sensor_count_next  = sensor_count_reg;
        current_slot_next  = current_slot_reg;
        res                = '0;
        res.action         = ACT_NONE;

        unique case (item.req_type)
            REQ_PACKET:
            begin
                if (item.crc_ok && item.packet_kind == PKT_DATA && sid_ok)
                begin
                    res.slot = item.slot_id;
                    if (item.disconnect)
                    begin
                        if (conn16[item.slot_id])
                        begin
                            connected_map_next = connected_map_reg & ~sid_hot[NUM_SLOTS-1:0];
                            sensor_count_next  = sensor_count_reg - 4'd1;
                        end
                        approval_map_next = approval_map_reg | sid_hot[NUM_SLOTS-1:0];
                        res.action        = ACT_REMOVED;
                    end
                    else
                    begin
                        res.action = ACT_STORED;
                    end
                end
                else if (item.crc_ok && item.packet_kind == PKT_JOIN)
                begin
                    if (free_found)
                    begin
                        connected_map_next = connected_map_reg | free_hot[NUM_SLOTS-1:0];
                        sensor_count_next  = sensor_count_reg + 4'd1;
                        res.action         = ACT_JOIN;
                        res.slot           = free_idx;
                        res.slot_offset    = join_offset;
                        res.window         = regs.listen_window;
                    end
                    else
                    begin
                        res.action = ACT_FULL;
                    end
                end
            end
            REQ_SYNC:
            begin
                res.action        = ACT_SYNC;
                res.approval_bits = appr16[3:0];
                res.power_code    = regs.tx_power;
                res.shutdown_code = regs.turn_off;
                approval_map_next = '0;
            end
            REQ_START, REQ_TICK:
            begin
                if (tick_used)
                begin
                    res.action         = ACT_LISTEN;
                    res.listen_channel = tick_slot;
                end
                else if (tick_slot != regs.advert_slot)
                begin
                    res.action         = ACT_LISTEN;
                    res.listen_channel = regs.advert_slot;
                end
                current_slot_next = tick_slot + 8'd1;
            end
            default:
            begin
                res.action = ACT_NONE;
            end
        endcase

        res.connected_count = sensor_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            connected_map_reg <= '0;
            approval_map_reg  <= '0;
            sensor_count_reg  <= 4'd0;
            current_slot_reg  <= 8'd0;
        end
        else if (fire)
        begin
            connected_map_reg <= connected_map_next;
            approval_map_reg  <= approval_map_next;
            sensor_count_reg  <= sensor_count_next;
            current_slot_reg  <= current_slot_next;
        end
    end

    // The count must always track the number of occupied slots.
    a_count_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        sensor_count_reg == 4'($countones(connected_map_reg)))
        else $error("sensor count out of step with connected map");

    a_sync_clears_approvals: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.req_type == REQ_SYNC |=> approval_map_reg == '0)
        else $error("approvals not cleared after sync");

    a_join_adds_one: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.req_type == REQ_PACKET && item.crc_ok && item.packet_kind == PKT_JOIN
        && !(&connected_map_reg)
        |=> sensor_count_reg == $past(sensor_count_reg) + 4'd1
            && $countones(connected_map_reg) == $countones($past(connected_map_reg)) + 1)
        else $error("join did not claim exactly one slot");

endmodule

FILE: hdl/tdma_host_slot_manager_unit.sv
// Top level of the TDMA host slot manager: input register, engine, result register.
// Depends on tshm_pkg, the channel interfaces, tshm_cfg_regs and tshm_engine.
//
// Each event transfer yields exactly one result transfer. An accepted event sits
// in the input register; its decode, slot search and the slot_unit * (2*slot+1)
// multiply run in the logic after that register, and the result lands in the
// output register. A new event is taken every cycle as long as the result side
// keeps taking results.
// The slot state is updated as an event moves into the output register, so
// consecutive events always see the effect of the ones before them.
// Configuration writes are taken every cycle and must be made while no event is
// in flight.
module tdma_host_slot_manager_unit import tshm_pkg::*;
#(
    parameter int NUM_SLOTS = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    tshm_in_if.sink   item,
    tshm_out_if.source result,
    tshm_cfg_if.sink  cfg
);

    cfg_t  regs;
    item_t in_reg;
    logic  in_valid_reg, in_valid_next;
    res_t  out_reg;
    logic  out_valid_reg, out_valid_next;
    res_t  res;
    logic  out_free;
    logic  fire;
    logic  take;

    tshm_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    tshm_engine #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_reg),
        .regs  (regs),
        .res   (res)
    );

    assign out_free   = !out_valid_reg || result.ready;
    assign fire       = in_valid_reg && out_free;
    assign item.ready = !in_valid_reg || fire;
    assign take       = item.valid && item.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_reg.req_type    <= req_t'(item.req_type);
            in_reg.crc_ok      <= item.crc_ok;
            in_reg.packet_kind <= item.packet_kind;
            in_reg.slot_id     <= item.slot_id;
            in_reg.disconnect  <= item.disconnect;
        end
        if (fire)
        begin
            out_reg <= res;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.action          = out_reg.action;
    assign result.slot            = out_reg.slot;
    assign result.slot_offset     = out_reg.slot_offset;
    assign result.window          = out_reg.window;
    assign result.approval_bits   = out_reg.approval_bits;
    assign result.power_code      = out_reg.power_code;
    assign result.shutdown_code   = out_reg.shutdown_code;
    assign result.connected_count = out_reg.connected_count;
    assign result.listen_channel  = out_reg.listen_channel;

endmodule

FILE: verif/tshm_checker.sv
// Checker for the TDMA host slot manager: keeps its own copy of the slot bookkeeping
// and compares every result transfer, field by field and in order, with its prediction.
// Depends on tshm_pkg and the channel interfaces of tshm_ifs.sv.
module tshm_checker import tshm_pkg::*;
#(
    parameter int NUM_SLOTS = 4
)
(
    input  logic clk,
    input  logic rst_n,
    tshm_in_if   item,
    tshm_out_if  result,
    tshm_cfg_if  cfg,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam cfg_t RESET_SETTINGS = '{
        slot_unit:     16'd4096,
        listen_window: 19'd32733,
        tx_power:      8'd1,
        turn_off:      8'd0,
        first_slot:    4'd0,
        advert_slot:   8'd4
    };

    cfg_t        settings;
    logic [15:0] conn_map;
    logic [15:0] approvals;
    logic [3:0]  sensors;
    logic [7:0]  cur_slot;
    res_t        pending_replies[$];
    res_t        want;
    item_t       taken;
    int          n_results;

    task automatic flag(string msg);
        $display("%0t ns: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
        if (got !== exp_val)
            flag($sformatf("result %0d, %s: got 0x%0h, expected 0x%0h",
                           n_results, name, got, exp_val));
    endtask

    // Works out the reply to one event and moves the bookkeeping on.
    function automatic res_t predict_slot_event(item_t ev);
        res_t r;
        int   s;
        int   i;
        r = '0;
        s = NUM_SLOTS;
        if (ev.req_type == REQ_PACKET) begin
            if (ev.crc_ok && ev.packet_kind == PKT_DATA && ev.slot_id < NUM_SLOTS) begin
                r.slot   = ev.slot_id;
                r.action = ev.disconnect ? ACT_REMOVED : ACT_STORED;
                if (ev.disconnect) begin
                    // An empty slot is still approved and reported, but the count holds.
                    if (conn_map[ev.slot_id]) begin
                        conn_map[ev.slot_id] = 1'b0;
                        sensors = sensors - 4'd1;
                    end
                    approvals[ev.slot_id] = 1'b1;
                end
            end else if (ev.crc_ok && ev.packet_kind == PKT_JOIN) begin
                for (i = NUM_SLOTS - 1; i >= 0; i--)
                    if (!conn_map[i])
                        s = i;
                if (s == NUM_SLOTS) begin
                    r.action = ACT_FULL;
                end else begin
                    conn_map[s]   = 1'b1;
                    sensors       = sensors + 4'd1;
                    r.action      = ACT_JOIN;
                    r.slot        = 4'(s);
                    r.slot_offset = 21'(32'(settings.slot_unit) * (2 * s + 1));
                    r.window      = settings.listen_window;
                end
            end
        end else if (ev.req_type == REQ_SYNC) begin
            r.action        = ACT_SYNC;
            r.approval_bits = approvals[3:0];
            r.power_code    = settings.tx_power;
            r.shutdown_code = settings.turn_off;
            approvals       = '0;
        end else begin
            if (ev.req_type == REQ_START)
                cur_slot = 8'(settings.first_slot);
            // Slots past the table count as empty.
            if (cur_slot < NUM_SLOTS && conn_map[cur_slot[3:0]]) begin
                r.action         = ACT_LISTEN;
                r.listen_channel = cur_slot;
            end else if (cur_slot != settings.advert_slot) begin
                r.action         = ACT_LISTEN;
                r.listen_channel = settings.advert_slot;
            end
            cur_slot = cur_slot + 8'd1;
        end
        r.connected_count = sensors;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            settings  = RESET_SETTINGS;
            conn_map  = '0;
            approvals = '0;
            sensors   = '0;
            cur_slot  = '0;
            n_results = 0;
            errors    = 0;
            pending_replies.delete();
            pending   = 0;
        end else begin
            // Results go first so that a stray one never pairs with a same-edge event.
            if (result.valid && result.ready) begin
                n_results++;
                if (pending_replies.size() == 0) begin
                    flag($sformatf("result %0d arrived with nothing expected", n_results));
                end else begin
                    want = pending_replies.pop_front();
                    check_field("action", result.action, want.action);
                    check_field("slot", result.slot, want.slot);
                    check_field("slot_offset", result.slot_offset, want.slot_offset);
                    check_field("window", result.window, want.window);
                    check_field("approval_bits", result.approval_bits, want.approval_bits);
                    check_field("power_code", result.power_code, want.power_code);
                    check_field("shutdown_code", result.shutdown_code, want.shutdown_code);
                    check_field("connected_count", result.connected_count,
                                want.connected_count);
                    check_field("listen_channel", result.listen_channel,
                                want.listen_channel);
                end
            end
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_SLOT_UNIT:     settings.slot_unit     = cfg.data[15:0];
                    CFG_LISTEN_WINDOW: settings.listen_window = cfg.data[18:0];
                    CFG_TX_POWER:      settings.tx_power      = cfg.data[7:0];
                    CFG_TURN_OFF:      settings.turn_off      = cfg.data[7:0];
                    CFG_FIRST_SLOT:    settings.first_slot    = cfg.data[3:0];
                    CFG_ADVERT_SLOT:   settings.advert_slot   = cfg.data[7:0];
                    default: ;
                endcase
            end
            if (item.valid && item.ready) begin
                taken.req_type    = req_t'(item.req_type);
                taken.crc_ok      = item.crc_ok;
                taken.packet_kind = item.packet_kind;
                taken.slot_id     = item.slot_id;
                taken.disconnect  = item.disconnect;
                pending_replies.push_back(predict_slot_event(taken));
            end
            pending = pending_replies.size();
        end
    end

endmodule

FILE: verif/tdma_host_slot_manager_unit_tb.sv
// Testbench top for the TDMA host slot manager: clock, reset, event and register
// stimulus with random idling, and the verdict. Depends on tshm_pkg, tshm_ifs.sv,
// the block itself and tshm_checker, which does all prediction and comparison.
module tdma_host_slot_manager_unit_tb import tshm_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS = 4;

    // Packet kinds that the block ignores.
    localparam logic [1:0] PKT_OTHER = 2'd2;
    localparam logic [1:0] PKT_SPARE = 2'd3;

    localparam cfg_t DEFAULT_SETTINGS = '{
        slot_unit:     16'd4096,
        listen_window: 19'd32733,
        tx_power:      8'd1,
        turn_off:      8'd0,
        first_slot:    4'd0,
        advert_slot:   8'd4
    };

    localparam cfg_t TOP_SETTINGS = '{
        slot_unit:     16'hFFFF,
        listen_window: 19'h7FFFF,
        tx_power:      8'hFF,
        turn_off:      8'hFF,
        first_slot:    4'hF,
        advert_slot:   8'hFF
    };

    logic clk = 1'b0;
    logic rst_n;
    int   errors;
    int   pending;
    bit   calm;
    bit   squeeze;

    tshm_in_if  item ();
    tshm_out_if result ();
    tshm_cfg_if cfg ();

    always #5 clk = ~clk;

    tdma_host_slot_manager_unit #(.NUM_SLOTS(NUM_SLOTS)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    tshm_checker #(.NUM_SLOTS(NUM_SLOTS)) bookkeeping_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .result  (result),
        .cfg     (cfg),
        .errors  (errors),
        .pending (pending)
    );

    function automatic item_t compose_item(req_t req, logic crc, logic [1:0] kind,
                                           logic [3:0] sid, logic disc);
        item_t ev;
        ev.req_type    = req;
        ev.crc_ok      = crc;
        ev.packet_kind = kind;
        ev.slot_id     = sid;
        ev.disconnect  = disc;
        return ev;
    endfunction

    // Mostly well-formed: data and joins with good CRC, other kinds, sync, starts, ticks.
    function automatic item_t random_item();
        item_t ev;
        int    pick;
        ev.req_type    = REQ_PACKET;
        ev.crc_ok      = ($urandom_range(0, 9) != 0);
        ev.packet_kind = 2'($urandom);
        ev.slot_id     = 4'($urandom);
        ev.disconnect  = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            ev.packet_kind = PKT_DATA;
            if ($urandom_range(0, 4) != 0)
                ev.slot_id = 4'($urandom_range(0, NUM_SLOTS - 1));
        end else if (pick < 55) begin
            ev.packet_kind = PKT_JOIN;
        end else if (pick < 63) begin
            ev.packet_kind = $urandom_range(0, 1) ? PKT_OTHER : PKT_SPARE;
            ev.crc_ok      = 1'($urandom);
        end else if (pick < 73) begin
            ev.req_type = REQ_SYNC;
        end else if (pick < 79) begin
            ev.req_type = REQ_START;
        end else begin
            ev.req_type = REQ_TICK;
        end
        return ev;
    endfunction

    // Called just after a rising edge; returns at the edge that completes the transfer.
    task automatic offer_event(item_t ev);
        if (!calm && $urandom_range(0, 3) == 0) begin
            item.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        item.valid       <= 1'b1;
        item.req_type    <= ev.req_type;
        item.crc_ok      <= ev.crc_ok;
        item.packet_kind <= ev.packet_kind;
        item.slot_id     <= ev.slot_id;
        item.disconnect  <= ev.disconnect;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
    endtask

    task automatic offer_random(int count);
        repeat (count)
            offer_event(random_item());
    endtask

    // Ends a phase: drops valid and waits until every reply has come back.
    task automatic settle();
        item.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic load_settings(cfg_t s);
        logic [CFG_IDX_W-1:0]  idx [6];
        logic [CFG_DATA_W-1:0] val [6];
        idx = '{CFG_SLOT_UNIT, CFG_LISTEN_WINDOW, CFG_TX_POWER,
                CFG_TURN_OFF, CFG_FIRST_SLOT, CFG_ADVERT_SLOT};
        val = '{19'(s.slot_unit), s.listen_window, 19'(s.tx_power),
                19'(s.turn_off), 19'(s.first_slot), 19'(s.advert_slot)};
        for (int k = 0; k < 6; k++) begin
            cfg.valid <= 1'b1;
            cfg.index <= idx[k];
            cfg.data  <= val[k];
            @(posedge clk);
            while (!cfg.ready)
                @(posedge clk);
        end
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // The result side: random stalls, long runs of ready, and one long hold-off on request.
    initial begin : result_taker
        result.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (squeeze) begin
                squeeze = 1'b0;
                result.ready <= 1'b0;
                repeat (60) @(posedge clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                result.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end else begin
                result.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        cfg_t s;
        rst_n            <= 1'b0;
        item.valid       <= 1'b0;
        item.req_type    <= REQ_PACKET;
        item.crc_ok      <= 1'b0;
        item.packet_kind <= PKT_DATA;
        item.slot_id     <= '0;
        item.disconnect  <= 1'b0;
        cfg.valid        <= 1'b0;
        cfg.index        <= CFG_SLOT_UNIT;
        cfg.data         <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset settings.
        offer_event(compose_item(REQ_TICK, 1'b0, PKT_DATA, 4'd0, 1'b0));
        offer_event(compose_item(REQ_SYNC, 1'b0, PKT_DATA, 4'd0, 1'b0));
        offer_event(compose_item(REQ_START, 1'b0, PKT_DATA, 4'd0, 1'b0));
        repeat (NUM_SLOTS + 1)
            offer_event(compose_item(REQ_PACKET, 1'b1, PKT_JOIN, 4'd0, 1'b0));
        offer_event(compose_item(REQ_PACKET, 1'b1, PKT_DATA, 4'd2, 1'b0));
        offer_event(compose_item(REQ_PACKET, 1'b1, PKT_DATA, 4'd15, 1'b1));
        offer_event(compose_item(REQ_PACKET, 1'b0, PKT_DATA, 4'd0, 1'b1));
        offer_event(compose_item(REQ_PACKET, 1'b1, PKT_OTHER, 4'd1, 1'b1));
        offer_event(compose_item(REQ_PACKET, 1'b1, PKT_SPARE, 4'd1, 1'b1));
        offer_event(compose_item(REQ_START, 1'b1, PKT_SPARE, 4'd15, 1'b1));
        repeat (NUM_SLOTS)
            offer_event(compose_item(REQ_TICK, 1'b0, PKT_DATA, 4'd0, 1'b0));
        offer_event(compose_item(REQ_PACKET, 1'b1, PKT_DATA, 4'd1, 1'b1));
        offer_event(compose_item(REQ_PACKET, 1'b1, PKT_DATA, 4'd1, 1'b1));
        offer_event(compose_item(REQ_SYNC, 1'b1, PKT_JOIN, 4'd7, 1'b1));
        offer_event(compose_item(REQ_PACKET, 1'b1, PKT_JOIN, 4'd0, 1'b0));
        offer_event(compose_item(REQ_PACKET, 1'b0, PKT_JOIN, 4'd0, 1'b0));
        offer_event(compose_item(REQ_PACKET, 1'b1, PKT_DATA, 4'd3, 1'b1));
        settle();

        // Top settings: the sequencer walks from the last start slot around the
        // 8-bit wrap, and reaches an empty slot equal to the advert channel.
        load_settings(TOP_SETTINGS);
        offer_event(compose_item(REQ_START, 1'b0, PKT_DATA, 4'd0, 1'b0));
        repeat (245)
            offer_event(compose_item(REQ_TICK, 1'($urandom), 2'($urandom),
                                     4'($urandom), 1'($urandom)));
        offer_random(100);
        settle();

        // All-zero settings, with a long hold-off on the result side.
        load_settings('0);
        squeeze = 1'b1;
        offer_random(150);
        settle();

        repeat (3) begin
            s.slot_unit     = 16'($urandom);
            s.listen_window = 19'($urandom);
            s.tx_power      = 8'($urandom);
            s.turn_off      = 8'($urandom);
            s.first_slot    = 4'($urandom);
            s.advert_slot   = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom);
            load_settings(s);
            offer_random(80);
            settle();
        end

        // Closing stretch at full rate on both sides.
        load_settings(DEFAULT_SETTINGS);
        calm = 1'b1;
        offer_random(60);
        item.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (10) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("tdma_host_slot_manager_unit_tb passed");
        else
            $display("tdma_host_slot_manager_unit_tb failed");
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("tdma_host_slot_manager_unit_tb failed");
        $finish;
    end

endmodule

FILE: files.f
hdl/tshm_pkg.sv
hdl/tshm_ifs.sv
hdl/tshm_cfg_regs.sv
hdl/tshm_engine.sv
hdl/tdma_host_slot_manager_unit.sv
verif/tshm_checker.sv
verif/tdma_host_slot_manager_unit_tb.sv
